/* rtl/ordered_key_set_with_successor_core_assert.svh */
// Assertion macros for the ordered key set core.
// Included by the top level; no other dependencies.
`ifndef ORDERED_KEY_SET_WITH_SUCCESSOR_CORE_ASSERT_SVH
`define ORDERED_KEY_SET_WITH_SUCCESSOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define OKSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("okss assertion failed");
`define OKSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("okss assertion failed");
`else
`define OKSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OKSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/okss_pkg.sv */
// Shared types and constants of the ordered key set core.
// No dependencies; used by okss_ffs and the top level.
package okss_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;
  localparam int unsigned WIDX_W = 6;
  localparam int unsigned KEY_W  = 12;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_CONTAINS  = 3'd2,
    CMD_SUCCESSOR = 3'd3,
    CMD_GETVALUE  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic             any;
    logic [BIT_W-1:0] idx;
  } ffs_res_t;

endpackage

/* rtl/ordered_key_set_with_successor_core.sv */
// Top level of the ordered key set core: sequencer, cluster word memory,
// summary register and value memory. Depends on okss_pkg, okss_ffs and the
// assertion header.
//
//  beat group  | dir | tdata fields (lowest bit up)
//  s_axis      | in  | command[2:0], key[14:3], value[46:15], zero fill to 48
//  m_axis      | out | found[0], result_key[12:1], result_value[44:13], fill
//
// Insert, remove, contains and get value go from the look to the output state;
// successor may also pass the summary, next cluster word and value states, set
// by the shared find-first-set unit (cluster word, summary, next cluster word)
// and the registered reads of both memories. The input is not ready until the
// result enters the output register, which waits while an earlier result beat
// is stalled. Reset empties the set through the summary register.
`include "ordered_key_set_with_successor_core_assert.svh"

module ordered_key_set_with_successor_core
  import okss_pkg::*;
#(
  parameter int unsigned UNIVERSE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], key[14:3], value[46:15], zero fill [47]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // found[0], result_key[12:1], result_value[44:13], zero fill [47:45]
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned NWORDS = (UNIVERSE + WORD_W - 1) / WORD_W;
  localparam int unsigned NW     = (NWORDS > WORD_W) ? WORD_W : NWORDS;
  localparam int unsigned WW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned VDEPTH = (UNIVERSE > (1 << KEY_W)) ? (1 << KEY_W) : UNIVERSE;
  localparam int unsigned VAW    = $clog2(VDEPTH);
  localparam logic [16:0] UNIV_L = 17'(UNIVERSE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SUM,
    S_WORD,
    S_VAL,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [KEY_W-1:0]   hit_q, hit_d;
  logic               res_found_q, res_found_d;
  logic [KEY_W-1:0]   res_key_q, res_key_d;
  logic [VAL_W-1:0]   res_val_q, res_val_d;
  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [KEY_W-1:0]   out_key_q, out_key_d;
  logic [VAL_W-1:0]   out_val_q, out_val_d;
  logic [WORD_W-1:0]  sum_q, sum_d;

  logic [WORD_W-1:0]  wmem [NW];
  logic [WORD_W-1:0]  wrd_q;
  logic [WIDX_W-1:0]  raddr_q, raddr_d;
  logic               wm_we;
  logic [WIDX_W-1:0]  wm_waddr;
  logic [WORD_W-1:0]  wm_wdata;

  logic [VAL_W-1:0]   vmem [VDEPTH];
  logic [VAL_W-1:0]   vrd_q;
  logic [KEY_W-1:0]   vraddr_q, vraddr_d;
  logic               vm_we;

  logic [KEY_W:0]     succ_key;
  logic               key_ok, succ_ok, here;
  logic [WORD_W-1:0]  word_cur, key_bit, word_set, word_clr;
  logic [WORD_W-1:0]  ffs_in;
  ffs_res_t           ffs_res;
  logic               in_acc;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign succ_key = {1'b0, key_q} + (KEY_W + 1)'(1);
  assign key_ok   = {5'b0, key_q} < UNIV_L;
  assign succ_ok  = {4'b0, succ_key} < UNIV_L;
  assign word_cur = sum_q[raddr_q] ? wrd_q : '0;
  assign key_bit  = WORD_W'(1) << key_q[BIT_W-1:0];
  assign here     = key_ok && ((word_cur & key_bit) != '0);
  assign word_set = word_cur | key_bit;
  assign word_clr = word_cur & ~key_bit;

  okss_ffs u_ffs (
    .vec_i (ffs_in),
    .res_o (ffs_res)
  );

  always_comb begin
    ffs_in = '0;
    unique case (state_q)
      S_LOOK:  ffs_in = word_cur & ({WORD_W{1'b1}} << succ_key[BIT_W-1:0]);
      S_SUM:   ffs_in = sum_q & (({WORD_W{1'b1}} << raddr_q) << 1);
      S_WORD:  ffs_in = word_cur;
      default: ffs_in = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    hit_d       = hit_q;
    res_found_d = res_found_q;
    res_key_d   = res_key_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_found_d = out_found_q;
    out_key_d   = out_key_q;
    out_val_d   = out_val_q;
    sum_d       = sum_q;
    raddr_d     = raddr_q;
    vraddr_d    = vraddr_q;
    wm_we       = 1'b0;
    wm_waddr    = key_q[KEY_W-1:BIT_W];
    wm_wdata    = word_set;
    vm_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d    = cmd_e'(s_axis_tdata[2:0]);
          key_d    = s_axis_tdata[14:3];
          val_d    = s_axis_tdata[46:15];
          vraddr_d = s_axis_tdata[14:3];
          if (cmd_e'(s_axis_tdata[2:0]) == CMD_SUCCESSOR) begin
            raddr_d = WIDX_W'((s_axis_tdata[14:3] + KEY_W'(1)) >> BIT_W);
          end else begin
            raddr_d = s_axis_tdata[14:9];
          end
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        res_key_d   = key_q;
        res_found_d = here;
        res_val_d   = here ? vrd_q : '0;
        state_d     = S_OUT;
        case (cmd_q)
          CMD_INSERT: begin
            if (key_ok) begin
              wm_we                   = 1'b1;
              wm_wdata                = word_set;
              sum_d[raddr_q]          = 1'b1;
              vm_we                   = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (here) begin
              wm_we    = 1'b1;
              wm_wdata = word_clr;
              if (word_clr == '0) begin
                sum_d[raddr_q] = 1'b0;
              end
            end
          end
          CMD_CONTAINS, CMD_GETVALUE: begin
          end
          CMD_SUCCESSOR: begin
            res_found_d = 1'b0;
            res_val_d   = '0;
            if (succ_ok) begin
              if (ffs_res.any) begin
                hit_d    = {raddr_q, ffs_res.idx};
                vraddr_d = {raddr_q, ffs_res.idx};
                state_d  = S_VAL;
              end else begin
                state_d = S_SUM;
              end
            end
          end
          default: begin
            res_found_d = 1'b0;
            res_val_d   = '0;
          end
        endcase
      end
      S_SUM: begin
        if (ffs_res.any) begin
          raddr_d = ffs_res.idx;
          state_d = S_WORD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_WORD: begin
        if (ffs_res.any) begin
          hit_d    = {raddr_q, ffs_res.idx};
          vraddr_d = {raddr_q, ffs_res.idx};
          state_d  = S_VAL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_VAL: begin
        res_found_d = 1'b1;
        res_key_d   = hit_q;
        res_val_d   = vrd_q;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_key_d   = res_key_q;
          out_val_d   = res_val_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    val_q       <= val_d;
    hit_q       <= hit_d;
    res_found_q <= res_found_d;
    res_key_q   <= res_key_d;
    res_val_q   <= res_val_d;
    out_found_q <= out_found_d;
    out_key_q   <= out_key_d;
    out_val_q   <= out_val_d;
    raddr_q     <= raddr_d;
    vraddr_q    <= vraddr_d;
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      wmem[wm_waddr[WW-1:0]] <= wm_wdata;
    end
    wrd_q <= wmem[raddr_d[WW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vmem[key_q[VAW-1:0]] <= val_q;
    end
    vrd_q <= vmem[vraddr_d[VAW-1:0]];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_val_q, out_key_q, out_found_q};

  `OKSS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready)
  `OKSS_ASSERT_IMP(a_absent_zero_value, clk_i, rst_ni,
                   m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[44:13] == '0)
  `OKSS_ASSERT_IMP(a_successor_greater, clk_i, rst_ni,
                   (state_q == S_OUT) && (cmd_q == CMD_SUCCESSOR) && res_found_q,
                   res_key_q > key_q)

endmodule

/* rtl/okss_ffs.sv */
// Shared find-first-set unit: lowest set bit of a 64-bit word.
// Depends on okss_pkg.
module okss_ffs
  import okss_pkg::*;
(
  input  logic [WORD_W-1:0] vec_i,
  output ffs_res_t          res_o
);

  logic [WORD_W-1:0] lsb;

  assign lsb = vec_i & (~vec_i + WORD_W'(1));

  always_comb begin
    res_o.any = |vec_i;
    res_o.idx = '0;
    for (int b = 0; b < BIT_W; b++) begin
      for (int p = 0; p < WORD_W; p++) begin
        if (((p >> b) & 1) != 0) begin
          res_o.idx[b] = res_o.idx[b] | lsb[p];
        end
      end
    end
  end

endmodule

/* verif/ordered_key_set_with_successor_core_tb.sv */
// Self-checking testbench for ordered_key_set_with_successor_core: directed and random
// insert, remove, lookup and successor beats, predicted by a scoreboard class.
// Depends on okss_pkg and the core's top level only.
module ordered_key_set_with_successor_core_tb;
  import okss_pkg::*;

  localparam int unsigned UNIVERSE = 4096;
  localparam int unsigned NWORDS = UNIVERSE / WORD_W;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned MAX_GAP = 17;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNKNOWN = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNKNOWN = 3'd7;

  typedef struct {
    logic             found;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } key_reply_t;

  class key_set_scoreboard;
    bit [WORD_W-1:0] cluster_words[NWORDS];
    logic [VAL_W-1:0] stored[UNIVERSE];
    key_reply_t replies_due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned successor_hits;
    int unsigned cmd_count[8];

    function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value);
      key_reply_t r;
      logic here;
      int unsigned w;
      int unsigned b;
      bit [WORD_W-1:0] m;
      r.found = 1'b0;
      r.key = key;
      r.value = '0;
      w = key / WORD_W;
      b = key % WORD_W;
      here = cluster_words[w][b];
      cmd_count[cmd]++;
      case (cmd)
        CMD_INSERT: begin
          if (here) begin
            r.found = 1'b1;
            r.value = stored[key];
          end
          cluster_words[w][b] = 1'b1;
          stored[key] = value;
        end
        CMD_REMOVE: begin
          if (here) begin
            r.found = 1'b1;
            r.value = stored[key];
            cluster_words[w][b] = 1'b0;
          end
        end
        CMD_CONTAINS, CMD_GETVALUE: begin
          if (here) begin
            r.found = 1'b1;
            r.value = stored[key];
          end
        end
        CMD_SUCCESSOR: begin
          m = cluster_words[w] & ~((64'd2 << b) - 64'd1);
          while (m == '0 && w < NWORDS - 1) begin
            w++;
            m = cluster_words[w];
          end
          if (m != '0) begin
            for (b = 0; m[b] == 1'b0; b++) ;
            r.found = 1'b1;
            r.key = KEY_W'(w * WORD_W + b);
            r.value = stored[r.key];
            successor_hits++;
          end
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_reply(logic [47:0] data);
      key_reply_t r;
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, data);
        return;
      end
      r = replies_due.pop_front();
      checked++;
      compare_field("found", VAL_W'(r.found), VAL_W'(data[0]));
      compare_field("result_key", VAL_W'(r.key), VAL_W'(data[12:1]));
      compare_field("result_value", r.value, data[44:13]);
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [47:0] m_axis_tdata;

  key_set_scoreboard sb = new;
  logic [KEY_W-1:0] key_pool[$];
  logic [KEY_W-1:0] hot_cluster[4];
  bit sender_steady;
  bit receiver_steady;
  bit long_hold_done;
  int unsigned cycle_count;

  ordered_key_set_with_successor_core #(
    .UNIVERSE(UNIVERSE)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
             sb.pending());
    $display("ordered_key_set_with_successor_core test failed");
    $finish;
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, value, key, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, key, value);
  endtask

  // Result side: random stalls, one long hold to back the block up, and a quiet stretch.
  initial begin
    int unsigned gap;
    m_axis_tready <= 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      receiver_steady = sb.checked >= 450 && sb.checked < 570;
      if (!long_hold_done && sb.checked == 250) begin
        gap = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        gap = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_reply(m_axis_tdata);
    end
  end

  initial begin
    int unsigned pick;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    sender_steady = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_GETVALUE, 12'd0, 32'hFFFF_FFFF);
    send_item(CMD_SUCCESSOR, 12'd0, '0);
    send_item(CMD_REMOVE, 12'd5, '0);
    send_item(CMD_INSERT, 12'd0, 32'h8000_0000);
    send_item(CMD_INSERT, 12'd4095, 32'h7FFF_FFFF);
    send_item(CMD_INSERT, 12'd0, 32'hFFFF_FFFF);
    send_item(CMD_CONTAINS, 12'd0, '0);
    send_item(CMD_GETVALUE, 12'd4095, '0);
    send_item(CMD_SUCCESSOR, 12'd0, '0);
    send_item(CMD_SUCCESSOR, 12'd4094, '0);
    send_item(CMD_SUCCESSOR, 12'd4095, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 12'd63, 32'd0);
    send_item(CMD_INSERT, 12'd64, 32'h1234_5678);
    send_item(CMD_SUCCESSOR, 12'd62, '0);
    send_item(CMD_SUCCESSOR, 12'd63, '0);
    send_item(CMD_REMOVE, 12'd64, '0);
    send_item(CMD_SUCCESSOR, 12'd63, '0);
    send_item(CMD_REMOVE, 12'd64, '0);
    send_item(CMD_REMOVE, 12'd4095, '0);
    send_item(CMD_SUCCESSOR, 12'd63, '0);
    send_item(CMD_INSERT, 12'd2048, 32'h5555_5555);
    send_item(CMD_INSERT, 12'd2049, 32'hAAAA_AAAA);
    send_item(CMD_FIRST_UNKNOWN, 12'd2048, 32'hFFFF_FFFF);
    send_item(CMD_FIRST_UNKNOWN + 3'd1, 12'd4095, '0);
    send_item(CMD_LAST_UNKNOWN, 12'd0, 32'hFFFF_FFFF);

    // Keys bunch in a few clusters and reuse earlier inserts, so lookups and
    // successor searches mostly hit; the rest spread over the whole universe.
    foreach (hot_cluster[i]) hot_cluster[i] = KEY_W'($urandom_range(0, NWORDS - 1) * WORD_W);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_steady = i >= 400 && i < 520;
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_INSERT;
      else if (pick < 45) cmd = CMD_REMOVE;
      else if (pick < 57) cmd = CMD_CONTAINS;
      else if (pick < 82) cmd = CMD_SUCCESSOR;
      else if (pick < 95) cmd = CMD_GETVALUE;
      else cmd = CMD_W'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
      pick = $urandom_range(0, 99);
      if (pick < 45) key = hot_cluster[$urandom_range(0, 3)] | KEY_W'($urandom_range(0, WORD_W - 1));
      else if (pick < 75 && key_pool.size() > 0) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else key = KEY_W'($urandom_range(0, UNIVERSE - 1));
      value = $urandom;
      if (cmd == CMD_INSERT) begin
        if (key_pool.size() < 64) key_pool.push_back(key);
        else key_pool[$urandom_range(0, 63)] = key;
      end
      send_item(cmd, key, value);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d inserts, %0d removes, %0d contains, %0d get value,",
             sb.checked, sb.cmd_count[CMD_INSERT], sb.cmd_count[CMD_REMOVE],
             sb.cmd_count[CMD_CONTAINS], sb.cmd_count[CMD_GETVALUE]);
    $display("%0d successor searches (%0d found a key) and %0d unknown commands.",
             sb.cmd_count[CMD_SUCCESSOR], sb.successor_hits,
             sb.cmd_count[5] + sb.cmd_count[6] + sb.cmd_count[7]);
    if (sb.mismatches == 0) begin
      $display("ordered_key_set_with_successor_core test passed");
    end else begin
      $display("ordered_key_set_with_successor_core test failed");
    end
    $finish;
  end

endmodule
